/* rtl/core/dhfk_pkg.sv */
// types, constants and angle table shared by the forward kinematics chain
`default_nettype none
package dhfk_pkg;

    localparam int CORDIC_STAGES = 31;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        S_IDLE,
        S_THETA,
        S_ALPHA,
        S_LOC,
        S_MAC,
        S_DRAIN,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_ST_CA,
        OP_ST_SA,
        OP_CT_CA,
        OP_CT_SA,
        OP_A_CT,
        OP_A_ST
    } loc_op_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } cordic_rsp_t;

    // atan(2^-i) as a binary angle, one turn = 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                5'd24:   v = 32'h00000029;
                5'd25:   v = 32'h00000014;
                5'd26:   v = 32'h0000000A;
                5'd27:   v = 32'h00000005;
                5'd28:   v = 32'h00000003;
                5'd29:   v = 32'h00000001;
                5'd30:   v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/dhfk_mul.sv */
// shared signed multiplier with registered product
`default_nettype none
module dhfk_mul (
    input  wire logic               clk,
    input  wire logic signed [31:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [64:0]      p
);

    logic signed [64:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 65'(a) * 65'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* rtl/core/dhfk_cordic.sv */
// iterative rotation-mode cordic giving cosine and sine of a binary angle
`default_nettype none
module dhfk_cordic #(
    parameter int ROT_FRAC_BITS = 30
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dhfk_pkg::cordic_req_t req,
    output dhfk_pkg::cordic_rsp_t     rsp
);

    localparam int SH = 30 - ROT_FRAC_BITS;
    localparam logic signed [33:0] RC  = 34'((64'd1 << SH) >> 1);
    localparam logic signed [33:0] ONE = 34'(64'd1 << ROT_FRAC_BITS);

    logic               busy_reg, done_reg;
    logic [4:0]         i_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [1:0]         q_reg;

    logic [31:0]        ang_rot, ru;
    logic [1:0]         q_in;
    logic signed [33:0] dx, dy, atn, xr, yr, xc, yc;
    logic signed [31:0] cx, cy;

    always_comb
    begin
        ang_rot = req.angle + 32'h2000_0000;
        q_in    = ang_rot[31:30];
        ru      = req.angle - {q_in, 30'b0};
        dx      = y_reg >>> i_reg;
        dy      = x_reg >>> i_reg;
        atn     = signed'({2'b00, dhfk_pkg::atan_turn(i_reg)});
        xr      = (x_reg + RC) >>> SH;
        yr      = (y_reg + RC) >>> SH;
        xc      = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
        yc      = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
        cx      = xc[31:0];
        cy      = yc[31:0];
    end

    // undo the quadrant fold
    always_comb
    begin
        rsp.done = done_reg;
        case (q_reg)
            2'd0:
            begin
                rsp.cos_v = cx;
                rsp.sin_v = cy;
            end
            2'd1:
            begin
                rsp.cos_v = -cy;
                rsp.sin_v = cx;
            end
            2'd2:
            begin
                rsp.cos_v = -cx;
                rsp.sin_v = -cy;
            end
            default:
            begin
                rsp.cos_v = cy;
                rsp.sin_v = -cx;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg + 5'd1;
            if (i_reg == 5'(dhfk_pkg::CORDIC_STAGES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= dhfk_pkg::CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= signed'({{2{ru[31]}}, ru});
            q_reg <= q_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atn;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atn;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/dh_forward_kinematics_chain.sv */
// link-parameter forward kinematics chain: one link row in, cumulative pose out
//
// Input channel: in_valid/in_stall carry one link row per word (angles, lengths,
// joint flags and value, last_row). A word is taken when in_valid is high and
// in_stall is low; in_stall stays high while a row is being worked on.
// Output channel: out_valid/out_stall carry the cumulative rotation (Q2.ROT_FRAC_BITS)
// and the saturated origin after each row.
// Sequence: two 31-step cordic passes (theta, then alpha) on one shared unit,
// then one shared multiplier runs 42 products (6 local terms, 27 rotation,
// 9 position), then a drain state and a write-back state. A new row is taken
// only after the previous row has passed through write-back.
// The result sits in an output register, so the next row is accepted while a
// finished word waits. If the receiver still stalls when the following row is
// done, the block holds in write-back with in_stall high until the word goes.
// Reset: the pose becomes identity rotation and zero origin; after a row marked
// last_row the pose is reloaded to identity once that row's word is formed.
`default_nettype none
module dh_forward_kinematics_chain #(
    parameter int ROT_FRAC_BITS = 30
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] theta_offset,
    input  wire logic signed [31:0] link_offset,
    input  wire logic signed [31:0] link_length,
    input  wire logic signed [31:0] twist_angle,
    input  wire logic               has_joint,
    input  wire logic               is_prismatic,
    input  wire logic signed [31:0] joint_value,
    input  wire logic               last_row,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      rot_00,
    output logic signed [31:0]      rot_01,
    output logic signed [31:0]      rot_02,
    output logic signed [31:0]      rot_10,
    output logic signed [31:0]      rot_11,
    output logic signed [31:0]      rot_12,
    output logic signed [31:0]      rot_20,
    output logic signed [31:0]      rot_21,
    output logic signed [31:0]      rot_22,
    output logic signed [39:0]      pos_x,
    output logic signed [39:0]      pos_y,
    output logic signed [39:0]      pos_z
);

    localparam int ACC_W = 67;
    localparam logic signed [31:0]      ONE  = 32'(64'd1 << ROT_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(64'd1 << (ROT_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] RLIM = ACC_W'((64'd1 << (ROT_FRAC_BITS + 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] PMAX = ACC_W'((64'd1 << 39) - 64'd1);
    localparam logic signed [ACC_W-1:0] PMIN = -ACC_W'(64'd1 << 39);
    localparam logic [1:0] COL_POS = 2'd3;
    localparam logic [1:0] LAST_IDX = 2'd2;

    dhfk_pkg::state_t  state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [1:0]        k_reg, k_next, r_reg, r_next, c_reg, c_next;
    logic              issue, issue_loc, fin;

    logic              tag_vld_reg, tag_loc_reg;
    dhfk_pkg::loc_op_t tag_op_reg;
    logic [1:0]        tag_k_reg, tag_r_reg, tag_c_reg;

    dhfk_pkg::cordic_req_t cordic_req;
    dhfk_pkg::cordic_rsp_t cordic_rsp;

    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] prod;

    logic [31:0]        theta_eff;
    logic signed [32:0] d_eff;

    logic [31:0]        alpha_reg;
    logic signed [31:0] len_reg;
    logic signed [32:0] d_reg;
    logic               last_reg;
    logic signed [31:0] ct_reg, st_reg, ca_reg, sa_reg;
    logic signed [31:0] l01_reg, l02_reg, l11_reg, l12_reg;
    logic signed [32:0] pa0_reg, pa1_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0] nr_reg [9];
    logic signed [39:0] np_reg [3];
    logic signed [31:0] rot_reg [9];
    logic signed [39:0] pos_reg [3];
    logic signed [31:0] orot_reg [9];
    logic signed [39:0] opos_reg [3];
    logic               out_valid_reg;

    logic signed [31:0] loc_w [9];
    logic signed [32:0] pa_k;
    logic [3:0]         rk_idx, wr_idx;

    logic signed [ACC_W-1:0] prod_x, rnd_prod, rsum, rclamp, psum, pclamp;
    logic signed [31:0]      rnd32;

    dhfk_cordic #(
        .ROT_FRAC_BITS(ROT_FRAC_BITS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (cordic_req),
        .rsp  (cordic_rsp)
    );

    dhfk_mul u_mul (
        .clk(clk),
        .a  (mul_a),
        .b  (mul_b),
        .p  (prod)
    );

    always_comb
    begin
        theta_eff = 32'(theta_offset) +
                    ((has_joint && !is_prismatic) ? 32'(joint_value) : 32'd0);
        d_eff     = 33'(link_offset) +
                    ((has_joint && is_prismatic) ? 33'(joint_value) : 33'sd0);
        loc_w[0] = ct_reg;
        loc_w[1] = l01_reg;
        loc_w[2] = l02_reg;
        loc_w[3] = st_reg;
        loc_w[4] = l11_reg;
        loc_w[5] = l12_reg;
        loc_w[6] = 32'sd0;
        loc_w[7] = sa_reg;
        loc_w[8] = ca_reg;
        rk_idx   = 4'(r_reg) * 4'd3 + 4'(k_reg);
        wr_idx   = 4'(tag_r_reg) * 4'd3 + 4'(tag_c_reg);
        case (k_reg)
            2'd0:    pa_k = pa0_reg;
            2'd1:    pa_k = pa1_reg;
            default: pa_k = d_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        cordic_req.start = 1'b0;
        cordic_req.angle = alpha_reg;
        issue            = 1'b0;
        issue_loc        = 1'b0;
        fin              = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        case (state_reg)
            dhfk_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cordic_req.start = 1'b1;
                    cordic_req.angle = theta_eff;
                    state_next       = dhfk_pkg::S_THETA;
                end
            end
            dhfk_pkg::S_THETA:
            begin
                if (cordic_rsp.done)
                begin
                    cordic_req.start = 1'b1;
                    state_next       = dhfk_pkg::S_ALPHA;
                end
            end
            dhfk_pkg::S_ALPHA:
            begin
                if (cordic_rsp.done)
                begin
                    cnt_next   = '0;
                    state_next = dhfk_pkg::S_LOC;
                end
            end
            dhfk_pkg::S_LOC:
            begin
                issue     = 1'b1;
                issue_loc = 1'b1;
                cnt_next  = cnt_reg + 3'd1;
                case (dhfk_pkg::loc_op_t'(cnt_reg))
                    dhfk_pkg::OP_ST_CA:
                    begin
                        mul_a = st_reg;
                        mul_b = 33'(ca_reg);
                    end
                    dhfk_pkg::OP_ST_SA:
                    begin
                        mul_a = st_reg;
                        mul_b = 33'(sa_reg);
                    end
                    dhfk_pkg::OP_CT_CA:
                    begin
                        mul_a = ct_reg;
                        mul_b = 33'(ca_reg);
                    end
                    dhfk_pkg::OP_CT_SA:
                    begin
                        mul_a = ct_reg;
                        mul_b = 33'(sa_reg);
                    end
                    dhfk_pkg::OP_A_CT:
                    begin
                        mul_a = len_reg;
                        mul_b = 33'(ct_reg);
                    end
                    default:
                    begin
                        mul_a = len_reg;
                        mul_b = 33'(st_reg);
                    end
                endcase
                if (dhfk_pkg::loc_op_t'(cnt_reg) == dhfk_pkg::OP_A_ST)
                begin
                    k_next     = '0;
                    r_next     = '0;
                    c_next     = '0;
                    state_next = dhfk_pkg::S_MAC;
                end
            end
            dhfk_pkg::S_MAC:
            begin
                // column 0 comes first: it needs none of the local terms just produced
                issue = 1'b1;
                mul_a = rot_reg[rk_idx];
                mul_b = (c_reg == COL_POS) ? pa_k : 33'(loc_w[4'(k_reg) * 4'd3 + 4'(c_reg)]);
                k_next = k_reg + 2'd1;
                if (k_reg == LAST_IDX)
                begin
                    k_next = '0;
                    r_next = r_reg + 2'd1;
                    if (r_reg == LAST_IDX)
                    begin
                        r_next = '0;
                        c_next = c_reg + 2'd1;
                        if (c_reg == COL_POS)
                        begin
                            state_next = dhfk_pkg::S_DRAIN;
                        end
                    end
                end
            end
            dhfk_pkg::S_DRAIN:
            begin
                state_next = dhfk_pkg::S_FIN;
            end
            dhfk_pkg::S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fin        = 1'b1;
                    state_next = dhfk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dhfk_pkg::S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != dhfk_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhfk_pkg::S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            tag_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                rot_reg[i] <= (i % 4 == 0) ? ONE : 32'sd0;
            end
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            tag_vld_reg <= issue;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < 9; i++)
                begin
                    rot_reg[i] <= last_reg ? ((i % 4 == 0) ? ONE : 32'sd0) : nr_reg[i];
                end
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[i] <= last_reg ? 40'sd0 : np_reg[i];
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // product write-back
    always_comb
    begin
        prod_x   = ACC_W'(prod);
        rnd_prod = (prod_x + RND) >>> ROT_FRAC_BITS;
        rnd32    = rnd_prod[31:0];
        rsum     = (acc_reg + prod_x) >>> ROT_FRAC_BITS;
        rclamp   = (rsum > RLIM) ? RLIM : ((rsum < -RLIM) ? -RLIM : rsum);
        psum     = acc_reg + rnd_prod;
        pclamp   = (psum > PMAX) ? PMAX : ((psum < PMIN) ? PMIN : psum);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dhfk_pkg::S_IDLE && in_valid)
        begin
            alpha_reg <= twist_angle;
            len_reg   <= link_length;
            d_reg     <= d_eff;
            last_reg  <= last_row;
        end
        if (state_reg == dhfk_pkg::S_THETA && cordic_rsp.done)
        begin
            ct_reg <= cordic_rsp.cos_v;
            st_reg <= cordic_rsp.sin_v;
        end
        if (state_reg == dhfk_pkg::S_ALPHA && cordic_rsp.done)
        begin
            ca_reg <= cordic_rsp.cos_v;
            sa_reg <= cordic_rsp.sin_v;
        end
        tag_loc_reg <= issue_loc;
        tag_op_reg  <= dhfk_pkg::loc_op_t'(cnt_reg);
        tag_k_reg   <= k_reg;
        tag_r_reg   <= r_reg;
        tag_c_reg   <= c_reg;
        if (tag_vld_reg)
        begin
            if (tag_loc_reg)
            begin
                case (tag_op_reg)
                    dhfk_pkg::OP_ST_CA: l01_reg <= -rnd32;
                    dhfk_pkg::OP_ST_SA: l02_reg <= rnd32;
                    dhfk_pkg::OP_CT_CA: l11_reg <= rnd32;
                    dhfk_pkg::OP_CT_SA: l12_reg <= -rnd32;
                    dhfk_pkg::OP_A_CT:  pa0_reg <= rnd_prod[32:0];
                    default:            pa1_reg <= rnd_prod[32:0];
                endcase
            end
            else if (tag_c_reg != COL_POS)
            begin
                // rounding constant rides in with the first term
                if (tag_k_reg == 2'd0)
                begin
                    acc_reg <= prod_x + RND;
                end
                else if (tag_k_reg != LAST_IDX)
                begin
                    acc_reg <= acc_reg + prod_x;
                end
                else
                begin
                    nr_reg[wr_idx] <= rclamp[31:0];
                end
            end
            else
            begin
                if (tag_k_reg == 2'd0)
                begin
                    acc_reg <= ACC_W'(pos_reg[tag_r_reg]) + rnd_prod;
                end
                else if (tag_k_reg != LAST_IDX)
                begin
                    acc_reg <= psum;
                end
                else
                begin
                    np_reg[tag_r_reg] <= pclamp[39:0];
                end
            end
        end
        if (fin)
        begin
            for (int i = 0; i < 9; i++)
            begin
                orot_reg[i] <= nr_reg[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                opos_reg[i] <= np_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign rot_00    = orot_reg[0];
    assign rot_01    = orot_reg[1];
    assign rot_02    = orot_reg[2];
    assign rot_10    = orot_reg[3];
    assign rot_11    = orot_reg[4];
    assign rot_12    = orot_reg[5];
    assign rot_20    = orot_reg[6];
    assign rot_21    = orot_reg[7];
    assign rot_22    = orot_reg[8];
    assign pos_x     = opos_reg[0];
    assign pos_y     = opos_reg[1];
    assign pos_z     = opos_reg[2];

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("row accepted but block not busy");

    a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_rsp.done |-> (state_reg == dhfk_pkg::S_THETA ||
                             state_reg == dhfk_pkg::S_ALPHA))
        else $error("cordic result outside an angle state");

    a_product_state: assert property (@(posedge clk) disable iff (!rst_n)
        tag_vld_reg |-> (state_reg == dhfk_pkg::S_LOC || state_reg == dhfk_pkg::S_MAC ||
                         state_reg == dhfk_pkg::S_DRAIN))
        else $error("product written back outside multiply phase");

endmodule
`default_nettype wire

/* dv/dh_forward_kinematics_chain_tb.sv */
// self-checking testbench for the forward kinematics chain
module dh_forward_kinematics_chain_tb;

    localparam int  ROT_FB = 30;
    localparam int  CYCLE_LIMIT = 900000;
    localparam int  HOLD_CYCLES = 600;
    localparam int  HOLD_AT_ROW = 250;
    localparam int  RANDOM_ROWS = 930;
    localparam longint GAIN_Q30 = 652032874;

    typedef struct packed {
        logic [31:0] theta;
        logic [31:0] d;
        logic [31:0] a;
        logic [31:0] alpha;
        logic        hj;
        logic        pr;
        logic [31:0] jv;
        logic        last;
        logic        drain;
    } link_row_t;

    typedef struct packed {
        logic [8:0][31:0] rot;
        logic [2:0][39:0] pos;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] theta_offset = '0;
    logic signed [31:0] link_offset = '0;
    logic signed [31:0] link_length = '0;
    logic signed [31:0] twist_angle = '0;
    logic has_joint = 1'b0;
    logic is_prismatic = 1'b0;
    logic signed [31:0] joint_value = '0;
    logic last_row = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
    logic signed [31:0] rot_20, rot_21, rot_22;
    logic signed [39:0] pos_x, pos_y, pos_z;

    dh_forward_kinematics_chain u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .theta_offset(theta_offset), .link_offset(link_offset),
        .link_length(link_length), .twist_angle(twist_angle),
        .has_joint(has_joint), .is_prismatic(is_prismatic),
        .joint_value(joint_value), .last_row(last_row),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12),
        .rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
    );

    longint atan_tbl [0:30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001};

    link_row_t rows_q[$];
    pose_t     pose_q[$];
    link_row_t cur_row;
    longint    rot_acc [0:8];
    longint    pos_acc [0:2];
    int        errors = 0;
    int        rows_in = 0;
    int        rows_out = 0;
    int        chains = 0;
    int        cycles = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    int        hold_cnt = 0;
    bit        hold_done = 1'b0;
    bit        quiet = 1'b0;
    bit        tail = 1'b0;
    logic      nv;
    logic      ns;
    pose_t     got;

    function automatic longint rnd_shift(longint v, int n);
        if (n == 0)
            return v;
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic cordic_sin_cos(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] q;
        logic [31:0] ru;
        longint x, y, z, dx, dy, one;
        q = ((ang + 32'h20000000) >> 30) & 32'd3;
        ru = ang - (q << 30);
        z = longint'($signed(ru));
        x = GAIN_Q30;
        y = 0;
        one = longint'(1) <<< ROT_FB;
        for (int i = 0; i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tbl[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_tbl[i];
            end
        end
        x = clip(rnd_shift(x, 30 - ROT_FB), -one, one);
        y = clip(rnd_shift(y, 30 - ROT_FB), -one, one);
        case (q)
            32'd0:   begin c = x;  s = y;  end
            32'd1:   begin c = -y; s = x;  end
            32'd2:   begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endtask

    task automatic pose_home();
        for (int i = 0; i < 9; i++)
            rot_acc[i] = (i % 4 == 0) ? (longint'(1) <<< ROT_FB) : 0;
        for (int i = 0; i < 3; i++)
            pos_acc[i] = 0;
    endtask

    // chain one link row onto the running pose and queue the expected word
    task automatic chain_link(input link_row_t rw);
        logic [31:0] th;
        longint d, a, ct, st, ca, sa, sum, ps, rlim, plim;
        longint lt [0:8];
        longint pa [0:2];
        longint nr [0:8];
        longint np [0:2];
        pose_t  pe;
        th = rw.theta;
        d = longint'($signed(rw.d));
        a = longint'($signed(rw.a));
        rlim = (longint'(1) <<< (ROT_FB + 1)) - 1;
        plim = (longint'(1) <<< 39) - 1;
        if (rw.hj)
        begin
            if (rw.pr)
                d += longint'($signed(rw.jv));
            else
                th = th + rw.jv;
        end
        cordic_sin_cos(th, ct, st);
        cordic_sin_cos(rw.alpha, ca, sa);
        lt[0] = ct;
        lt[1] = -rnd_shift(st * ca, ROT_FB);
        lt[2] = rnd_shift(st * sa, ROT_FB);
        lt[3] = st;
        lt[4] = rnd_shift(ct * ca, ROT_FB);
        lt[5] = -rnd_shift(ct * sa, ROT_FB);
        lt[6] = 0;
        lt[7] = sa;
        lt[8] = ca;
        pa[0] = rnd_shift(a * ct, ROT_FB);
        pa[1] = rnd_shift(a * st, ROT_FB);
        pa[2] = d;
        for (int r = 0; r < 3; r++)
        begin
            ps = 0;
            for (int c = 0; c < 3; c++)
            begin
                sum = 0;
                for (int k = 0; k < 3; k++)
                    sum += rot_acc[r * 3 + k] * lt[k * 3 + c];
                nr[r * 3 + c] = clip(rnd_shift(sum, ROT_FB), -rlim, rlim);
            end
            for (int k = 0; k < 3; k++)
                ps += rnd_shift(rot_acc[r * 3 + k] * pa[k], ROT_FB);
            np[r] = clip(pos_acc[r] + ps, -plim - 1, plim);
        end
        for (int k = 0; k < 9; k++)
        begin
            rot_acc[k] = nr[k];
            pe.rot[k] = nr[k][31:0];
        end
        for (int k = 0; k < 3; k++)
        begin
            pos_acc[k] = np[k];
            pe.pos[k] = np[k][39:0];
        end
        pose_q.push_back(pe);
        if (rw.last)
            pose_home();
    endtask

    task automatic add_row(input logic [31:0] th, input logic [31:0] d, input logic [31:0] a,
                           input logic [31:0] al, input logic hj, input logic pr,
                           input logic [31:0] jv, input logic last, input logic drain);
        link_row_t rw;
        rw = '{th, d, a, al, hj, pr, jv, last, drain};
        rows_q.push_back(rw);
        if (last)
            chains++;
    endtask

    task automatic add_random_row(input logic last);
        add_row($urandom, $urandom, $urandom, $urandom, $urandom_range(1), $urandom_range(1),
                $urandom, last, 1'b0);
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles, pose_q.size());
            $display("dh_forward_kinematics_chain_tb: done, errors");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            nv = in_valid;
            if (in_valid && !in_stall)
            begin
                chain_link(cur_row);
                rows_in++;
                nv = 1'b0;
                if (!tail && $urandom_range(3) == 0)
                    in_gap = $urandom_range(13, 1);
            end
            if (!nv)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (rows_q.size() > 0 && !(rows_q[0].drain && pose_q.size() > 0))
                begin
                    cur_row = rows_q.pop_front();
                    nv = 1'b1;
                    theta_offset <= cur_row.theta;
                    link_offset  <= cur_row.d;
                    link_length  <= cur_row.a;
                    twist_angle  <= cur_row.alpha;
                    has_joint    <= cur_row.hj;
                    is_prismatic <= cur_row.pr;
                    joint_value  <= cur_row.jv;
                    last_row     <= cur_row.last;
                end
            end
            in_valid <= nv;
            tail = rows_q.size() < 100;
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.rot = {rot_22, rot_21, rot_20, rot_12, rot_11, rot_10, rot_02, rot_01, rot_00};
                got.pos = {pos_z, pos_y, pos_x};
                rows_out++;
                if (pose_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: word with nothing due, rot_00 %h pos_x %h", $time, rot_00, pos_x);
                end
                else
                begin
                    for (int k = 0; k < 9; k++)
                        if (got.rot[k] !== pose_q[0].rot[k])
                        begin
                            errors++;
                            $display("%0t: rot_%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                                     pose_q[0].rot[k], got.rot[k]);
                        end
                    for (int k = 0; k < 3; k++)
                        if (got.pos[k] !== pose_q[0].pos[k])
                        begin
                            errors++;
                            $display("%0t: pos[%0d] expected %h actual %h", $time, k,
                                     pose_q[0].pos[k], got.pos[k]);
                        end
                    void'(pose_q.pop_front());
                end
            end
            if (cycles % 256 == 0)
                quiet = $urandom_range(3) == 0;
            if (!hold_done && rows_in >= HOLD_AT_ROW)
            begin
                hold_done = 1'b1;
                hold_cnt = HOLD_CYCLES;
            end
            ns = 1'b0;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                ns = 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                ns = 1'b1;
            end
            else if (!tail && !quiet && $urandom_range(7) == 0)
            begin
                out_gap = $urandom_range(12, 0);
                ns = 1'b1;
            end
            out_stall <= ns;
        end
    end

    initial
    begin
        pose_home();
        // identity link, then quarter-turn folds and extremes of the angles
        add_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
        add_row(32'h40000000, 32'h00010000, 32'h00010000, 32'h40000000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
        add_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
        add_row(32'hC0000000, 32'h80000000, 32'h7FFFFFFF, 32'hC0000000, 1'b0, 1'b0, 32'h0, 1'b1, 1'b0);
        add_row(32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0);
        add_row(32'h20000000, 32'h0, 32'h7FFFFFFF, 32'hE0000000, 1'b0, 1'b0, 32'h0, 1'b1, 1'b0);
        // revolute angle wrap around one turn
        add_row(32'h7FFFFFFF, 32'h0, 32'h00050000, 32'h0, 1'b1, 1'b0, 32'h00000001, 1'b0, 1'b0);
        add_row(32'h80000000, 32'h0, 32'h00050000, 32'h0, 1'b1, 1'b0, 32'hFFFFFFFF, 1'b0, 1'b0);
        add_row(32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h80000000, 1'b1, 1'b0);
        // prismatic sum past 32 bits
        add_row(32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b0, 1'b0);
        add_row(32'h0, 32'h80000000, 32'h0, 32'h0, 1'b1, 1'b1, 32'h80000000, 1'b1, 1'b0);
        // joint flags ignored when there is no joint
        add_row(32'h12345678, 32'h00100000, 32'h00200000, 32'h10000000, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b0, 1'b0);
        add_row(32'h12345678, 32'h00100000, 32'h00200000, 32'h10000000, 1'b0, 1'b0, 32'h7FFFFFFF, 1'b1, 1'b0);
        // last row with all-ones fields
        add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b0);
        // random chains, mostly short and well formed
        while (rows_q.size() < RANDOM_ROWS)
        begin
            int len;
            len = $urandom_range(8, 1);
            if (rows_q.size() > 400 && rows_q.size() < 410)
                add_row($urandom, $urandom, $urandom, $urandom, 1'b1, 1'b0, $urandom, 1'b0, 1'b1);
            for (int i = 0; i < len; i++)
                add_random_row(i == len - 1 ? 1'b1 : ($urandom_range(15) == 0));
            if (rows_q.size() > 600 && rows_q.size() < 609)
            begin
                // long prismatic reach to drive the origin into saturation
                for (int i = 0; i < 140; i++)
                    add_row(32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,
                            1'b1, 1'b1, 32'h7FFFFFFF, i == 139, 1'b0);
                add_row(32'h0, 32'h80000000, 32'h0, 32'h0, 1'b1, 1'b1, 32'h80000000, 1'b0, 1'b0);
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (rows_q.size() == 0 && !in_valid && pose_q.size() == 0);
        repeat (250) @(posedge clk);
        if (pose_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d words never arrived", $time, pose_q.size());
        end
        $display("%0d link rows in %0d chains driven, %0d pose words checked, %0d errors",
                 rows_in, chains, rows_out, errors);
        if (errors == 0)
            $display("dh_forward_kinematics_chain_tb: done, clean");
        else
            $display("dh_forward_kinematics_chain_tb: done, errors");
        $finish;
    end
endmodule
